>>> sv/mkh_pkg.sv
// Shared constants and types for the Meiyan key hash unit.
package mkh_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned CHUNK_W = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned MULT_W  = 20;
    localparam int unsigned ROT_AMT = 5;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'h811c_9dc5;
    localparam logic [MULT_W-1:0] HASH_MULT = 20'had3e7;

    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [CHUNK_W-1:0] chunk_t;

endpackage

>>> sv/meiyan_key_hash_unit.sv
// Meiyan key hash: sequencer around one shared XOR-multiply unit.
// A non-last chunk is accepted, then folded in by one multiply step before the next is accepted.
// A last chunk is accepted, then mixed in multiply steps (none for an empty tail, else one
// full word, or up to three halves and one byte), then finished; m_tready may hold the finish.
// The single 32x20 multiplier is used once per cycle, in ST_MIX only.
// aresetn (synchronous, active low) loads the seed and empties the output register.
module meiyan_key_hash_unit
    import mkh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // chunk_data[63:0], valid_bytes[67:64], zero pad
    input  logic        s_tlast,   // last_chunk
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hash_value[31:0]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_FINISH
    } state_t;

    state_t              state_reg,    state_next;
    hash_t               hash_reg,     hash_next;
    chunk_t              chunk_reg,    chunk_next;
    logic                full_reg,     full_next;
    logic                last_reg,     last_next;
    logic [2:0]          rem_reg,      rem_next;
    hash_t               out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;

    logic [CHUNK_W-1:0]  in_chunk;
    logic [CNT_W-1:0]    in_cnt;
    logic                in_full;
    hash_t               lo_word, hi_word, rot_word;
    hash_t               operand;
    logic [HASH_W+MULT_W-1:0] product;
    logic                s_fire;
    logic                m_fire;

    assign in_chunk = s_tdata[CHUNK_W-1:0];
    assign in_cnt   = s_tdata[CHUNK_W+CNT_W-1:CHUNK_W];
    assign in_full  = !s_tlast || in_cnt[CNT_W-1];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign lo_word  = chunk_reg[HASH_W-1:0];
    assign hi_word  = chunk_reg[CHUNK_W-1:HASH_W];
    assign rot_word = {lo_word[HASH_W-ROT_AMT-1:0], lo_word[HASH_W-1:HASH_W-ROT_AMT]};

    // pick the word folded in this cycle: full word, next half, or sign-extended byte
    always_comb begin
        if (full_reg) begin
            operand = rot_word ^ hi_word;
        end else if (rem_reg >= 3'd2) begin
            operand = {16'd0, chunk_reg[15:0]};
        end else begin
            operand = {{24{chunk_reg[7]}}, chunk_reg[7:0]};
        end
    end

    assign product = (hash_reg ^ operand) * HASH_MULT;

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        chunk_next     = chunk_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (m_fire) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    chunk_next = in_chunk;
                    full_next  = in_full;
                    last_next  = s_tlast;
                    rem_next   = in_cnt[2:0];
                    if (!in_full && in_cnt[2:0] == 3'd0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                hash_next = product[HASH_W-1:0];
                if (full_reg) begin
                    full_next  = 1'b0;
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end else if (rem_reg >= 3'd2) begin
                    rem_next   = rem_reg - 3'd2;
                    chunk_next = {16'd0, chunk_reg[CHUNK_W-1:16]};
                    if (rem_reg == 3'd2) begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    rem_next   = 3'd0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = hash_reg ^ {16'd0, hash_reg[HASH_W-1:16]};
                    out_valid_next = 1'b1;
                    hash_next      = HASH_SEED;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= HASH_SEED;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
            rem_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            full_reg      <= full_next;
            last_reg      <= last_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
        chunk_reg    <= chunk_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_valid_reg && !m_tready) |=> (state_reg == ST_FINISH))
        else $error("finish left while output register still full");

    a_seed_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!out_valid_reg || m_tready))
            |=> (hash_reg == HASH_SEED && out_valid_reg))
        else $error("seed not reloaded after a finished key");

    a_full_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX && full_reg) |=> !full_reg)
        else $error("full-word step repeated");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result appeared outside finish");
`endif

endmodule
